/* design/pctd_pkg.sv */
package pctd_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int VALUE_FIELD_W   = 16;
  localparam int BLOCK_W         = 16;
  localparam int TOTAL_W         = 32;

  localparam int FIRST_DIV_A   = 2;
  localparam int FIRST_DIV_B   = 3;
  localparam int D_FIRST       = 5;
  localparam int D_STEP        = 6;
  localparam int PAIR_GAP      = 2;
  localparam int SQ_FIRST      = 25;
  localparam int INC_FIRST     = 96;
  localparam int INC_STEP      = 72;
  localparam int LARGEST_SMALL = 3;
  localparam int SMALLEST_PRIME = 2;

  typedef struct packed {
    logic [VALUE_FIELD_W-1:0] value;
    logic                     last_in_block;
  } in_beat_t;

  typedef struct packed {
    logic               is_prime;
    logic [BLOCK_W-1:0] block_primes;
    logic [TOTAL_W-1:0] total_primes;
    logic               block_end;
  } out_beat_t;

  localparam int STEP_W = 3;

  localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SMALL = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DIV   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_CHECK = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;

  localparam logic [2:0] OP_FETCH = 3'd0;
  localparam logic [2:0] OP_SMALL = 3'd1;
  localparam logic [2:0] OP_DIV   = 3'd2;
  localparam logic [2:0] OP_CHECK = 3'd3;
  localparam logic [2:0] OP_EMIT  = 3'd4;
  localparam logic [2:0] OP_NOP   = 3'd5;

  typedef struct packed {
    logic [2:0]        op;
    logic [STEP_W-1:0] jmp_t;
    logic [STEP_W-1:0] jmp_f;
  } ucw_t;

  function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] pc);
    ucw_t w;
    case (pc)
      STEP_FETCH: w = '{op: OP_FETCH, jmp_t: STEP_SMALL, jmp_f: STEP_FETCH};
      STEP_SMALL: w = '{op: OP_SMALL, jmp_t: STEP_EMIT,  jmp_f: STEP_DIV};
      STEP_DIV:   w = '{op: OP_DIV,   jmp_t: STEP_DIV,   jmp_f: STEP_CHECK};
      STEP_CHECK: w = '{op: OP_CHECK, jmp_t: STEP_EMIT,  jmp_f: STEP_DIV};
      STEP_EMIT:  w = '{op: OP_EMIT,  jmp_t: STEP_FETCH, jmp_f: STEP_EMIT};
      default:    w = '{op: OP_NOP,   jmp_t: STEP_FETCH, jmp_f: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* design/pctd_rem_unit.sv */
module pctd_rem_unit
  import pctd_pkg::*;
#(
  parameter int W = VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         clear,
  input  logic         step,
  input  logic         bit_in,
  input  logic [W-1:0] divisor,
  output logic         rem_zero
);

  logic [W-1:0] rem_r;
  logic [W-1:0] rem_nxt;
  logic [W:0]   trial;

  always_comb begin
    trial   = {rem_r, bit_in};
    rem_nxt = rem_r;
    if (clear) begin
      rem_nxt = '0;
    end else if (step) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  assign rem_zero = (rem_r == '0);

endmodule

/* design/prime_count_trial_division_core.sv */
// Tests one unsigned value per beat for primality by trial division with the pair 2, 3 and then
// the divisor pairs 6k-1 and 6k+1, and counts primes per block and since reset, both counts
// saturating. A beat with last_in_block set returns the block count including itself and then
// clears it. A small microcoded sequencer drives two bit-serial remainder units that test a pair
// of divisors in parallel, one quotient bit per cycle. Values below 4 are settled in the SMALL
// step without division; otherwise each pair is tried by DIV steps over every value bit and then
// a CHECK step, and the loop ends at the first divisor found or when d*d exceeds the value, so
// even values and multiples of three end after the first pair. A finished result waits in the
// EMIT step until the output register is empty.
// A new value is taken while a finished result still waits in the output register.
module prime_count_trial_division_core
  import pctd_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W);

  logic [STEP_W-1:0] pc_r, pc_nxt;
  ucw_t              uw;
  logic              cond;

  logic [W-1:0]  v_r, v_nxt;
  logic          last_r, last_nxt;
  logic          prime_r, prime_nxt;
  logic [W-1:0]  sh_r, sh_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  da_r, da_nxt;
  logic [W-1:0]  db_r, db_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W:0]    sq_r, sq_nxt;
  logic [W:0]    inc_r, inc_nxt;

  logic [BLOCK_W-1:0] block_r, block_nxt, block_inc;
  logic [TOTAL_W-1:0] total_r, total_nxt, total_inc;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  logic [31:0]  value_ext;
  logic [W-1:0] v_in;
  logic         rem_clear, rem_step;
  logic         zero_a, zero_b;
  logic         in_fire, slot_free, small_val, found, sq_over;

  assign value_ext = 32'(in_data.value);
  assign v_in      = value_ext[W-1:0];
  assign uw        = ucode_rom(pc_r);
  assign in_ready  = (uw.op == OP_FETCH);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign small_val = (v_r <= W'(LARGEST_SMALL));
  assign found     = zero_a || zero_b;
  assign sq_over   = (sq_r > {1'b0, v_r});

  assign block_inc = (block_r != '1) ? block_r + 1'b1 : block_r;
  assign total_inc = (total_r != '1) ? total_r + 1'b1 : total_r;

  pctd_rem_unit #(.W(W)) u_rem_a (
    .clk      (clk),
    .clear    (rem_clear),
    .step     (rem_step),
    .bit_in   (sh_r[W-1]),
    .divisor  (da_r),
    .rem_zero (zero_a)
  );

  pctd_rem_unit #(.W(W)) u_rem_b (
    .clk      (clk),
    .clear    (rem_clear),
    .step     (rem_step),
    .bit_in   (sh_r[W-1]),
    .divisor  (db_r),
    .rem_zero (zero_b)
  );

  always_comb begin
    v_nxt         = v_r;
    last_nxt      = last_r;
    prime_nxt     = prime_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    inc_nxt       = inc_r;
    block_nxt     = block_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rem_clear     = 1'b0;
    rem_step      = 1'b0;
    cond          = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (uw.op)
      OP_FETCH: begin
        cond = in_fire;
        if (in_fire) begin
          v_nxt     = v_in;
          last_nxt  = in_data.last_in_block;
          sh_nxt    = v_in;
          cnt_nxt   = CW'(W - 1);
          da_nxt    = W'(FIRST_DIV_A);
          db_nxt    = W'(FIRST_DIV_B);
          d_nxt     = W'(D_FIRST);
          sq_nxt    = (W+1)'(SQ_FIRST);
          inc_nxt   = (W+1)'(INC_FIRST);
          rem_clear = 1'b1;
        end
      end
      OP_SMALL: begin
        cond      = small_val;
        prime_nxt = (v_r >= W'(SMALLEST_PRIME));
      end
      OP_DIV: begin
        cond     = (cnt_r != '0);
        rem_step = 1'b1;
        sh_nxt   = sh_r << 1;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_CHECK: begin
        cond      = found || sq_over;
        prime_nxt = !found;
        if (!found && !sq_over) begin
          sh_nxt    = v_r;
          cnt_nxt   = CW'(W - 1);
          da_nxt    = d_r;
          db_nxt    = W'(d_r + W'(PAIR_GAP));
          d_nxt     = W'(d_r + W'(D_STEP));
          sq_nxt    = (W+1)'(sq_r + inc_r);
          inc_nxt   = (W+1)'(inc_r + (W+1)'(INC_STEP));
          rem_clear = 1'b1;
        end
      end
      OP_EMIT: begin
        cond = slot_free;
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.is_prime     = prime_r;
          out_data_nxt.block_primes = prime_r ? block_inc : block_r;
          out_data_nxt.total_primes = prime_r ? total_inc : total_r;
          out_data_nxt.block_end    = last_r;
          total_nxt = prime_r ? total_inc : total_r;
          if (last_r) begin
            block_nxt = '0;
          end else begin
            block_nxt = prime_r ? block_inc : block_r;
          end
        end
      end
      default: begin
        cond = 1'b1;
      end
    endcase

    pc_nxt = cond ? uw.jmp_t : uw.jmp_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_FETCH;
      block_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      block_r     <= block_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    last_r     <= last_nxt;
    prime_r    <= prime_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    inc_r      <= inc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_block_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    TOTAL_W'(block_r) <= total_r)
    else $error("block count exceeds total count");

  a_fetch_to_small: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pc_r == STEP_SMALL))
    else $error("accepted value did not start the test");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_DIV) |-> (da_r != '0) && (db_r != '0))
    else $error("remainder step with zero divisor");

  a_check_after_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_CHECK) |-> $past(pc_r) == STEP_DIV && $past(cnt_r) == '0)
    else $error("pair checked before the remainders finished");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_EMIT) && slot_free |=> out_valid_r)
    else $error("emit step left the output register empty");

endmodule

/* dv/prime_count_trial_division_core_tb.sv */
module prime_count_trial_division_core_tb;
  import pctd_pkg::*;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int DRAIN_CYCLES  = 1000;
  localparam int RANDOM_ITEMS  = 110;
  localparam int HOLD_CYCLES   = 3000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned error_count;

  logic [BLOCK_W-1:0] block_tally;
  logic [TOTAL_W-1:0] grand_tally;
  out_beat_t          due_results[$];

  prime_count_trial_division_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic prime_by_division(input logic [VALUE_FIELD_W-1:0] value);
    int unsigned n;
    int unsigned d;
    n = 32'(value);
    if (n < SMALLEST_PRIME) return 1'b0;
    if (n <= LARGEST_SMALL) return 1'b1;
    if (n % FIRST_DIV_A == 0 || n % FIRST_DIV_B == 0) return 1'b0;
    for (d = D_FIRST; d * d <= n; d += D_STEP) begin
      if (n % d == 0 || n % (d + PAIR_GAP) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void flag_field(input string name, input logic [TOTAL_W-1:0] want,
                                     input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    out_beat_t want;
    logic      hit;
    if (!rst_n) begin
      block_tally = '0;
      grand_tally = '0;
    end else begin
      if (in_valid && in_ready) begin
        hit = prime_by_division(in_data.value);
        if (hit && block_tally != '1) block_tally++;
        if (hit && grand_tally != '1) grand_tally++;
        want.is_prime     = hit;
        want.block_primes = block_tally;
        want.total_primes = grand_tally;
        want.block_end    = in_data.last_in_block;
        due_results.push_back(want);
        if (in_data.last_in_block) block_tally = '0;
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing expected, actual %h", $time, out_data);
        end else begin
          want = due_results.pop_front();
          flag_field("is_prime", TOTAL_W'(want.is_prime), TOTAL_W'(out_data.is_prime));
          flag_field("block_primes", TOTAL_W'(want.block_primes),
                     TOTAL_W'(out_data.block_primes));
          flag_field("total_primes", want.total_primes, out_data.total_primes);
          flag_field("block_end", TOTAL_W'(want.block_end), TOTAL_W'(out_data.block_end));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [VALUE_FIELD_W-1:0] pick_value();
    int unsigned k;
    k = $urandom_range(3);
    if (k == 0) return VALUE_FIELD_W'($urandom_range(300));
    if (k == 1) begin
      k = $urandom_range(1, 10922) * D_STEP;
      return VALUE_FIELD_W'($urandom_range(1) ? k + 1 : k - 1);
    end
    return VALUE_FIELD_W'($urandom_range(65535));
  endfunction

  task automatic send_beat(input logic [VALUE_FIELD_W-1:0] value, input logic last);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= in_beat_t'{value: value, last_in_block: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_corner_values();
    logic [VALUE_FIELD_W:0] corners[] = '{
      {16'd0, 1'b0}, {16'd1, 1'b0}, {16'd2, 1'b0}, {16'd3, 1'b0}, {16'd4, 1'b0},
      {16'd5, 1'b0}, {16'd6, 1'b1}, {16'd9, 1'b1}, {16'd7, 1'b0}, {16'd25, 1'b0},
      {16'd35, 1'b0}, {16'd49, 1'b0}, {16'd121, 1'b0}, {16'd143, 1'b0},
      {16'd289, 1'b0}, {16'd63001, 1'b0}, {16'd65521, 1'b0}, {16'd65535, 1'b0},
      {16'd32768, 1'b1}, {16'd1, 1'b1}, {16'd2, 1'b1}, {16'd65521, 1'b1}
    };
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    foreach (corners[i]) send_beat(corners[i][VALUE_FIELD_W:1], corners[i][0]);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (RANDOM_ITEMS) send_beat(pick_value(), $urandom_range(7) == 0);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so the
  // core fills up and has to drop in_ready.
  task automatic test_output_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = HOLD_CYCLES;
    repeat (40) send_beat(VALUE_FIELD_W'($urandom_range(300)), $urandom_range(7) == 0);
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 0;
    hold_left      = 0;
    cycle_count    = 0;
    error_count    = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corner_values();
    test_random_traffic(0, 0);
    test_random_traffic(62, 0);
    test_random_traffic(0, 62);
    test_random_traffic(15, 15);
    test_output_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
